@@ rtl/assert_macros.svh @@
// Assertion macros of the checker module of the serial LED/key driver.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked and disabled during reset.
`define LKSD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lksd assertion failed");

// Overlapping implication, clocked and disabled during reset.
`define LKSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lksd implication failed");

`endif

@@ rtl/lksd_pkg.sv @@
// Types, codes and frame tables of the serial LED/key driver.
// No dependencies.
package lksd_pkg;

   localparam int CLEAR_BYTES     = 16;
   localparam int DIGIT_SLOTS     = 4;
   localparam int SEG_LATCH_DEPTH = 4;
   localparam int STEP_W          = 5;

   // command codes
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_INIT  = 3'd1;
   localparam logic [2:0] CMD_ONE   = 3'd2;
   localparam logic [2:0] CMD_FOUR  = 3'd3;
   localparam logic [2:0] CMD_OFF   = 3'd4;
   localparam logic [2:0] CMD_ON    = 3'd5;
   localparam logic [2:0] CMD_READ  = 3'd6;
   localparam logic [2:0] CMD_RSVD  = 3'd7;

   // frame bytes
   localparam logic [7:0] BYTE_DATA_AUTO = 8'h40;
   localparam logic [7:0] BYTE_DATA_READ = 8'h42;
   localparam logic [7:0] BYTE_ADDR_BASE = 8'hC0;
   localparam logic [7:0] BYTE_DISP_ON   = 8'h88;
   localparam logic [7:0] BYTE_DISP_OFF  = 8'h80;
   localparam logic [7:0] BYTE_BLANK     = 8'h00;

   localparam logic [STEP_W-1:0] INIT_END_IDX  = STEP_W'(2 + CLEAR_BYTES);
   localparam logic [STEP_W-1:0] INIT_FEND_IDX = STEP_W'(1 + CLEAR_BYTES);
   localparam logic [STEP_W-1:0] FOUR_END_IDX  = STEP_W'(2 + 2 * DIGIT_SLOTS);
   localparam logic [STEP_W-1:0] FOUR_FEND_IDX = STEP_W'(1 + 2 * DIGIT_SLOTS);

   typedef logic [SEG_LATCH_DEPTH-1:0][7:0] seg_array_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] position;
      logic [3:0] value;
      logic [3:0] digit_first;
      logic [3:0] digit_second;
      logic [3:0] digit_third;
      logic [3:0] digit_fourth;
      logic       dio_in;
   } req_item_type;

   typedef struct packed {
      logic       strobe_res;
      logic       clock_pin;
      logic       dio_out;
      logic       dio_drive;
      logic       busy_res;
      logic       cmd_taken;
      logic       key_valid;
      logic [7:0] key_byte;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fend;
      logic       last;
      logic       rd;
   } frame_byte_type;

   function automatic logic [7:0] seg_code(input logic [3:0] v);
      logic [7:0] c;
      case (v)
         4'd0:    c = 8'h3F;
         4'd1:    c = 8'h06;
         4'd2:    c = 8'h5B;
         4'd3:    c = 8'h4F;
         4'd4:    c = 8'h66;
         4'd5:    c = 8'h6D;
         4'd6:    c = 8'h7D;
         4'd7:    c = 8'h07;
         4'd8:    c = 8'h7F;
         4'd9:    c = 8'h6F;
         default: c = BYTE_BLANK;
      endcase
      return c;
   endfunction

   // Byte number idx of a command's sequence, with frame-end, last and read marks.
   function automatic frame_byte_type seq_byte(input logic [2:0] cmd,
                                               input logic [STEP_W-1:0] idx,
                                               input logic [2:0] addr,
                                               input seg_array_type seg);
      frame_byte_type   r;
      logic [STEP_W-1:0] k;
      r = '{data: BYTE_BLANK, fend: 1'b0, last: 1'b0, rd: 1'b0};
      k = idx - STEP_W'(2);
      case (cmd)
         CMD_INIT: begin
            if (idx == '0) begin
               r.data = BYTE_DATA_AUTO;
               r.fend = 1'b1;
            end else if (idx == STEP_W'(1)) begin
               r.data = BYTE_ADDR_BASE;
            end else if (idx < INIT_END_IDX) begin
               r.fend = (idx == INIT_FEND_IDX);
            end else begin
               r.data = BYTE_DISP_ON;
               r.fend = 1'b1;
               r.last = 1'b1;
            end
         end
         CMD_ONE: begin
            if (idx == '0) begin
               r.data = BYTE_ADDR_BASE + {4'b0, addr, 1'b0};
            end else begin
               r.data = seg[0];
               r.fend = 1'b1;
               r.last = 1'b1;
            end
         end
         CMD_FOUR: begin
            if (idx == '0) begin
               r.data = BYTE_DATA_AUTO;
               r.fend = 1'b1;
            end else if (idx == STEP_W'(1)) begin
               r.data = BYTE_ADDR_BASE;
            end else if (idx < FOUR_END_IDX) begin
               // even slots carry a code, odd slots and slots past the latch are blank
               if (!k[0] && (k[STEP_W-1:3] == '0)) begin
                  r.data = seg[k[2:1]];
               end
               r.fend = (idx == FOUR_FEND_IDX);
            end else begin
               r.data = BYTE_DISP_ON;
               r.fend = 1'b1;
               r.last = 1'b1;
            end
         end
         CMD_OFF: begin
            r.data = BYTE_DISP_OFF;
            r.fend = 1'b1;
            r.last = 1'b1;
         end
         CMD_ON: begin
            r.data = BYTE_DISP_ON;
            r.fend = 1'b1;
            r.last = 1'b1;
         end
         CMD_READ: begin
            if (idx == '0) begin
               r.data = BYTE_DATA_READ;
            end else begin
               r.rd   = 1'b1;
               r.fend = 1'b1;
               r.last = 1'b1;
            end
         end
         default: begin
            r.fend = 1'b1;
            r.last = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

@@ rtl/lksd_seq.sv @@
// Pin sequencer of the serial LED/key driver: one half-bit tick per step.
// Depends on lksd_pkg.
module lksd_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  lksd_pkg::req_item_type item,
   output lksd_pkg::rsp_item_type result
);

   logic [2:0]                    active_ff, active_in;
   logic [lksd_pkg::STEP_W-1:0]   step_ff, step_in, step_inc;
   logic [2:0]                    bit_ff, bit_in;
   logic                          half_ff, half_in;
   logic                          gap_ff, gap_in;
   logic [7:0]                    out_shift_ff, out_shift_in;
   logic [7:0]                    key_shift_ff, key_shift_in;
   logic [2:0]                    addr_ff, addr_in;
   lksd_pkg::seg_array_type       seg_ff, seg_in;
   lksd_pkg::frame_byte_type      cur, nxt, first;
   logic                          ok;

   assign step_inc = step_ff + lksd_pkg::STEP_W'(1);
   assign cur      = lksd_pkg::seq_byte(active_ff, step_ff, addr_ff, seg_ff);
   assign nxt      = lksd_pkg::seq_byte(active_ff, step_inc, addr_ff, seg_ff);
   assign first    = lksd_pkg::seq_byte(item.cmd, '0, item.position[2:0], seg_ff);

   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      half_in      = half_ff;
      gap_in       = gap_ff;
      out_shift_in = out_shift_ff;
      key_shift_in = key_shift_ff;
      addr_in      = addr_ff;
      seg_in       = seg_ff;
      ok           = 1'b0;
      result       = '{strobe_res: 1'b1, clock_pin: 1'b1, dio_out: 1'b0, dio_drive: 1'b1,
                       busy_res: 1'b0, cmd_taken: 1'b0, key_valid: 1'b0, key_byte: 8'h00};
      if (active_ff == lksd_pkg::CMD_NONE) begin
         ok = (item.cmd != lksd_pkg::CMD_NONE) && (item.cmd != lksd_pkg::CMD_RSVD);
         // drop a single digit with a bad position or value
         if (item.cmd == lksd_pkg::CMD_ONE && (item.position > 4'd7 || item.value > 4'd9)) begin
            ok = 1'b0;
         end
         if (ok) begin
            result.cmd_taken = 1'b1;
            result.busy_res  = 1'b1;
            active_in        = item.cmd;
            if (item.cmd == lksd_pkg::CMD_ONE) begin
               addr_in   = item.position[2:0];
               seg_in[0] = lksd_pkg::seg_code(item.value);
            end else if (item.cmd == lksd_pkg::CMD_FOUR) begin
               seg_in[0] = lksd_pkg::seg_code(item.digit_first);
               seg_in[1] = lksd_pkg::seg_code(item.digit_second);
               seg_in[2] = lksd_pkg::seg_code(item.digit_third);
               seg_in[3] = lksd_pkg::seg_code(item.digit_fourth);
            end
            step_in      = '0;
            bit_in       = '0;
            half_in      = 1'b0;
            key_shift_in = '0;
            gap_in       = 1'b0;
            out_shift_in = first.data;
         end
      end else if (gap_ff) begin
         // strobe high for one tick between frames
         result.busy_res = 1'b1;
         gap_in          = 1'b0;
         half_in         = 1'b0;
         bit_in          = '0;
      end else begin
         result.busy_res   = 1'b1;
         result.strobe_res = 1'b0;
         if (cur.rd) begin
            result.dio_drive = 1'b0;
         end else begin
            result.dio_out = out_shift_ff[bit_ff];
         end
         if (!half_ff) begin
            result.clock_pin = 1'b0;
            half_in          = 1'b1;
         end else begin
            half_in = 1'b0;
            if (cur.rd && item.dio_in) begin
               key_shift_in[bit_ff] = 1'b1;
            end
            if (bit_ff != 3'd7) begin
               bit_in = bit_ff + 3'd1;
            end else begin
               bit_in = '0;
               if (cur.rd) begin
                  result.key_valid = 1'b1;
                  result.key_byte  = key_shift_in;
               end
               if (cur.last) begin
                  active_in = lksd_pkg::CMD_NONE;
                  step_in   = '0;
               end else begin
                  // advance to the next byte, open a gap after a frame end
                  step_in      = step_inc;
                  out_shift_in = nxt.data;
                  if (nxt.rd) begin
                     key_shift_in = '0;
                  end
                  gap_in = cur.fend;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= lksd_pkg::CMD_NONE;
         step_ff      <= '0;
         bit_ff       <= '0;
         half_ff      <= 1'b0;
         gap_ff       <= 1'b0;
         out_shift_ff <= '0;
         key_shift_ff <= '0;
         addr_ff      <= '0;
      end else if (step_en) begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         half_ff      <= half_in;
         gap_ff       <= gap_in;
         out_shift_ff <= out_shift_in;
         key_shift_ff <= key_shift_in;
         addr_ff      <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         seg_ff <= seg_in;
      end
   end

endmodule

@@ rtl/led_key_serial_driver.sv @@
// Serial LED/key driver: one tick item in, one pin-state result out.
// An input transfer passes the input register and then the result register to reach its result.
// Throughput: one item per cycle while the result register is not stalled; the sequencer steps once per item.
// Reset (synchronous, active high): sequencer idle, strobe high, both stages empty.
// Depends on lksd_pkg and lksd_seq.
module led_key_serial_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // position[3:0], value[7:4], digit_first[11:8],
                                    // digit_second[15:12], digit_third[19:16],
                                    // digit_fourth[23:20], dio_in[24], zero[31:25]
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // strobe_res[0], clock_pin[1], dio_out[2], dio_drive[3],
                                    // busy_res[4], cmd_taken[5], key_valid[6],
                                    // key_byte[14:7], zero[15]
);

   logic                   s1_valid_ff;
   lksd_pkg::req_item_type s1_item_ff;
   lksd_pkg::req_item_type req_item;
   logic                   rsp_valid_ff;
   lksd_pkg::rsp_item_type rsp_item_ff;
   lksd_pkg::rsp_item_type seq_result;
   logic                   adv;

   assign req_item = '{cmd:          req_tuser,
                       position:     req_tdata[3:0],
                       value:        req_tdata[7:4],
                       digit_first:  req_tdata[11:8],
                       digit_second: req_tdata[15:12],
                       digit_third:  req_tdata[19:16],
                       digit_fourth: req_tdata[23:20],
                       dio_in:       req_tdata[24]};

   // step when the result register is free or drains this cycle
   assign adv        = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || adv;

   lksd_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (adv),
      .item    (s1_item_ff),
      .result  (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_item_ff <= seq_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_item_ff.key_byte, rsp_item_ff.key_valid,
                        rsp_item_ff.cmd_taken, rsp_item_ff.busy_res, rsp_item_ff.dio_drive,
                        rsp_item_ff.dio_out, rsp_item_ff.clock_pin, rsp_item_ff.strobe_res};

endmodule

@@ rtl/lksd_checker.sv @@
// Port-level checks of the serial LED/key driver, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lksd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic unused_req;

   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata) ^ (^req_tuser);

   // a stalled result holds
   `LKSD_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, ##1 (rsp_tvalid && $stable(rsp_tdata)))
   // a taken command starts busy with strobe still high
   `LKSD_ASSERT_IMPL(a_taken_busy, clock, reset, rsp_tvalid && rsp_tdata[5], rsp_tdata[4] && rsp_tdata[0])
   // a key byte completes on a clock-high tick with dio released
   `LKSD_ASSERT_IMPL(a_key_phase, clock, reset, rsp_tvalid && rsp_tdata[6], rsp_tdata[1] && !rsp_tdata[3] && !rsp_tdata[0])
   // strobe low only inside a busy sequence
   `LKSD_ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[4] && !rsp_tdata[5])

endmodule

bind led_key_serial_driver lksd_checker u_lksd_checker (.*);
